// File: design/lcd4_pkg.sv
// Shared types and constants for the 4-bit character LCD transfer planner.
// No dependencies; every other design file imports this package.
package lcd4_pkg;

	// request opcodes
	localparam logic [1:0] OP_CMD    = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_CURSOR = 2'd2;
	localparam logic [1:0] OP_INIT   = 2'd3;

	// register indexes on the APB port
	localparam logic [1:0] REG_STROBE_WIDTH = 2'd0;
	localparam logic [1:0] REG_BYTE_GAP     = 2'd1;
	localparam logic [1:0] REG_CLEAR_EXTRA  = 2'd2;
	localparam logic [1:0] REG_POWERUP_WAIT = 2'd3;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam int WAIT_W = 16;

	localparam logic [WAIT_W-1:0] RST_STROBE_WIDTH = 16'd1000;
	localparam logic [WAIT_W-1:0] RST_BYTE_GAP     = 16'd2000;
	localparam logic [WAIT_W-1:0] RST_CLEAR_EXTRA  = 16'd2000;
	localparam logic [WAIT_W-1:0] RST_POWERUP_WAIT = 16'd15000;

	localparam logic [WAIT_W-1:0] INIT_WAIT_FIRST  = 16'd5000;
	localparam logic [WAIT_W-1:0] INIT_WAIT_SECOND = 16'd200;

	localparam logic [7:0] LINE0_BASE = 8'h80;
	localparam logic [7:0] LINE1_BASE = 8'hC0;

	localparam logic [3:0] NIB_WAKE  = 4'h3;
	localparam logic [3:0] NIB_4BIT  = 4'h2;
	localparam logic [7:0] CMD_FUNC  = 8'h28;
	localparam logic [7:0] CMD_DISP  = 8'h0C;
	localparam logic [7:0] CMD_ENTRY = 8'h06;
	localparam logic [7:0] CMD_CLEAR = 8'h01;

	// init runs 4 bare nibbles then 4 command bytes
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_FIRST_BYTE = 4'd4;
	localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 4'd11;
	localparam logic [STEP_W-1:0] STEP_BYTE_LAST  = 4'd1;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
		logic       row;
		logic [5:0] col;
	} req_t;

	typedef struct packed {
		logic              reg_select;
		logic [3:0]        nibble;
		logic [WAIT_W-1:0] wait_before;
		logic [WAIT_W-1:0] wait_after;
		logic              last;
	} xfer_t;

	// classified job handed from front to back
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
	} job_t;

	// timing values the back end needs
	typedef struct packed {
		logic [WAIT_W-1:0] byte_gap;
		logic [WAIT_W-1:0] clear_wait;
		logic [WAIT_W-1:0] powerup_wait;
	} timing_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} back_state_t;

	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = CMD_FUNC;
			2'd1:    c = CMD_DISP;
			2'd2:    c = CMD_ENTRY;
			default: c = CMD_CLEAR;
		endcase
		return c;
	endfunction

endpackage

// File: design/char_lcd_4bit_interface.sv
// A taken request is queued, popped by the sequencer, and each transfer registered.
// Throughput: one transfer per cycle from the back-end sequencer; a byte request is
// two nibbles, init 4 nibbles then 4 bytes; queued requests follow with no gap.
// busy is high while the job queue (QUEUE_DEPTH entries) is full.
// Reset (arst_n low, async): queue empty, sequencer idle, registers at defaults.
// Depends on lcd4_pkg, lcd4_regs, lcd4_front, lcd4_queue, lcd4_back.
module char_lcd_4bit_interface #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  lcd4_pkg::req_t              req,
	output logic                        busy,
	output logic                        strobe,
	output lcd4_pkg::xfer_t             result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcd4_pkg::APB_AW-1:0] paddr,
	input  logic [lcd4_pkg::APB_DW-1:0] pwdata,
	output logic [lcd4_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import lcd4_pkg::*;

	timing_t timing;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	job_t    new_job;
	job_t    head_job;

	lcd4_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.timing  (timing)
	);

	lcd4_front u_front (
		.start  (start),
		.req    (req),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.job    (new_job)
	);

	lcd4_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	lcd4_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_job),
		.empty  (q_empty),
		.timing (timing),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// File: design/lcd4_regs.sv
// APB register file: strobe width, byte gap, clear extra wait, power-up wait.
// Depends on lcd4_pkg; also forms the saturated clear-command wait.
module lcd4_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [lcd4_pkg::APB_AW-1:0] paddr,
	input  logic [lcd4_pkg::APB_DW-1:0] pwdata,
	output logic [lcd4_pkg::APB_DW-1:0] prdata,
	output logic                     pready,
	output lcd4_pkg::timing_t        timing
);
	import lcd4_pkg::*;

	logic [WAIT_W-1:0] strobe_width_q;
	logic [WAIT_W-1:0] byte_gap_q;
	logic [WAIT_W-1:0] clear_extra_q;
	logic [WAIT_W-1:0] powerup_wait_q;
	logic              wr_en;
	logic [1:0]        idx;
	logic [WAIT_W:0]   clear_sum;
	logic [WAIT_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_width_q <= RST_STROBE_WIDTH;
			byte_gap_q     <= RST_BYTE_GAP;
			clear_extra_q  <= RST_CLEAR_EXTRA;
			powerup_wait_q <= RST_POWERUP_WAIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_STROBE_WIDTH: strobe_width_q <= pwdata[WAIT_W-1:0];
				REG_BYTE_GAP:     byte_gap_q     <= pwdata[WAIT_W-1:0];
				REG_CLEAR_EXTRA:  clear_extra_q  <= pwdata[WAIT_W-1:0];
				REG_POWERUP_WAIT: powerup_wait_q <= pwdata[WAIT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STROBE_WIDTH: rd_val = strobe_width_q;
			REG_BYTE_GAP:     rd_val = byte_gap_q;
			REG_CLEAR_EXTRA:  rd_val = clear_extra_q;
			REG_POWERUP_WAIT: rd_val = powerup_wait_q;
			default:          rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DW-WAIT_W){1'b0}}, rd_val};

	// clear wait saturates at the top of the 16-bit range
	assign clear_sum = {1'b0, byte_gap_q} + {1'b0, clear_extra_q};

	always_comb begin
		timing.byte_gap     = byte_gap_q;
		timing.powerup_wait = powerup_wait_q;
		timing.clear_wait   = clear_sum[WAIT_W] ? {WAIT_W{1'b1}} : clear_sum[WAIT_W-1:0];
	end

endmodule

// File: design/lcd4_front.sv
// Front end: takes a request transfer and turns it into a job descriptor.
// Depends on lcd4_pkg; feeds lcd4_queue.
module lcd4_front (
	input  logic           start,
	input  lcd4_pkg::req_t req,
	input  logic           q_full,
	output logic           busy,
	output logic           push,
	output lcd4_pkg::job_t job
);
	import lcd4_pkg::*;

	logic [7:0] line_base;

	assign busy = q_full;
	assign push = start & ~q_full;
	assign line_base = req.row ? LINE1_BASE : LINE0_BASE;

	always_comb begin
		job = '0;
		unique case (req.op)
			OP_CMD: begin
				job.rs   = 1'b0;
				job.data = req.value;
			end
			OP_DATA: begin
				job.rs   = 1'b1;
				job.data = req.value;
			end
			OP_CURSOR: begin
				// address wraps at 8 bits
				job.rs   = 1'b0;
				job.data = line_base + {2'b00, req.col};
			end
			OP_INIT: begin
				job.is_init = 1'b1;
			end
			default: job = '0;
		endcase
	end

endmodule

// File: design/lcd4_queue.sv
// Small job queue between front and back end.
// Depends on lcd4_pkg for the job descriptor type.
module lcd4_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcd4_pkg::job_t push_job,
	input  logic           pop,
	output lcd4_pkg::job_t head,
	output logic           empty,
	output logic           full
);
	import lcd4_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_FULL);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/lcd4_back.sv
// Back end: steps through a job and emits one strobed transfer per cycle.
// Depends on lcd4_pkg; pops jobs from lcd4_queue.
module lcd4_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lcd4_pkg::job_t    head,
	input  logic              empty,
	input  lcd4_pkg::timing_t timing,
	output logic              pop,
	output logic              strobe,
	output lcd4_pkg::xfer_t   result
);
	import lcd4_pkg::*;

	back_state_t       state_q, state_d;
	job_t              job_q;
	logic [STEP_W-1:0] step_q;
	logic              last_step;
	logic              running;
	logic [STEP_W-1:0] cmd_step;
	logic [7:0]        cur_byte;
	xfer_t             xfer;
	xfer_t             result_q;
	logic              strobe_q;

	assign last_step = job_q.is_init ? (step_q == STEP_INIT_LAST) : (step_q == STEP_BYTE_LAST);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!empty) state_d = ST_RUN;
			ST_RUN:  if (last_step && empty) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop     = 1'b0;
		running = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = ~empty;
			ST_RUN: begin
				running = 1'b1;
				pop     = last_step & ~empty;
			end
			default: ;
		endcase
	end

	assign cmd_step = step_q - STEP_FIRST_BYTE;
	assign cur_byte = job_q.is_init ? init_cmd(cmd_step[2:1]) : job_q.data;

	always_comb begin
		xfer = '0;
		xfer.last = last_step;
		if (job_q.is_init) begin
			xfer.reg_select = 1'b0;
			if (step_q < STEP_FIRST_BYTE) begin
				xfer.nibble = (step_q == 4'd3) ? NIB_4BIT : NIB_WAKE;
				if (step_q == 4'd0) begin
					xfer.wait_before = timing.powerup_wait;
					xfer.wait_after  = INIT_WAIT_FIRST;
				end else if (step_q == 4'd1) begin
					xfer.wait_after  = INIT_WAIT_SECOND;
				end
			end else if (step_q[0]) begin
				xfer.nibble     = cur_byte[3:0];
				xfer.wait_after = last_step ? timing.clear_wait : timing.byte_gap;
			end else begin
				xfer.nibble = cur_byte[7:4];
			end
		end else begin
			xfer.reg_select = job_q.rs;
			if (step_q[0]) begin
				xfer.nibble     = cur_byte[3:0];
				xfer.wait_after = timing.byte_gap;
			end else begin
				xfer.nibble = cur_byte[7:4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= running;
			if (pop) begin
				step_q <= '0;
			end else if (running) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (running) begin
			result_q <= xfer;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// File: design/lcd4_checker.sv
// Port-level checks on the transfer stream of char_lcd_4bit_interface.
// Depends on lcd4_pkg; bound to the top level below.
module lcd4_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            strobe,
	input lcd4_pkg::xfer_t result
);
	import lcd4_pkg::*;

	// only the first init transfer carries a pre-strobe wait
	a_before_only_init: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.wait_before != '0 |-> !result.reg_select && result.nibble == NIB_WAKE
		&& !result.last)
		else $error("wait_before on a transfer other than the first init nibble");

	// after the first init transfer the sequence continues without a gap
	a_init_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.wait_before != '0 |=> strobe && result.wait_before == '0)
		else $error("init sequence broke after its first transfer");

	// a data byte's high nibble is followed at once by its low nibble
	a_data_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.reg_select && !result.last |=> strobe && result.reg_select && result.last)
		else $error("data byte low nibble missing");

	// high nibble of a data byte never carries a settle wait
	a_data_high_nowait: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.reg_select && !result.last |-> result.wait_after == '0)
		else $error("data high nibble with nonzero wait_after");

endmodule

bind char_lcd_4bit_interface lcd4_checker u_lcd4_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.result (result)
);

// File: dv/tb.sv
// Self-checking bench for char_lcd_4bit_interface: requests go in on start/busy, LCD bus
// transfers are checked against an in-bench transfer planner. Registers set over APB.
// Depends on lcd4_pkg and the design files.
module tb;
	import lcd4_pkg::*;

	localparam int STALL_LIMIT = 2000;

	// bus protocol values the planner expects
	localparam logic [7:0]  LCD_LINE0_ADDR = 8'h80;
	localparam logic [7:0]  LCD_LINE1_ADDR = 8'hC0;
	localparam logic [7:0]  LCD_FUNC_SET   = 8'h28;
	localparam logic [7:0]  LCD_DISP_ON    = 8'h0C;
	localparam logic [7:0]  LCD_ENTRY_MODE = 8'h06;
	localparam logic [7:0]  LCD_CLEAR_DISP = 8'h01;
	localparam logic [3:0]  WAKE_NIB       = 4'h3;
	localparam logic [3:0]  FOURBIT_NIB    = 4'h2;
	localparam logic [15:0] WAKE_WAIT_1ST  = 16'd5000;
	localparam logic [15:0] WAKE_WAIT_2ND  = 16'd200;

	typedef struct {
		req_t        r;
		int unsigned gap;
	} lcd_req_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	req_t                req_in = '0;
	logic                busy;
	logic                strobe;
	xfer_t               result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// register shadows
	logic [15:0] strobe_width_q = 16'd1000;
	logic [15:0] byte_gap_q     = 16'd2000;
	logic [15:0] clear_extra_q  = 16'd2000;
	logic [15:0] powerup_wait_q = 16'd15000;

	lcd_req_item_t req_pending_q[$];
	lcd_req_item_t req_head;
	xfer_t         xfer_expect_q[$];
	xfer_t         xfer_want;
	int            err_cnt = 0;
	int            stall_cycles = 0;

	char_lcd_4bit_interface dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req_in),
		.busy(busy),
		.strobe(strobe),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic xfer_t mk_xfer(input logic rs, input logic [3:0] nib,
			input logic [15:0] wb, input logic [15:0] wa, input logic lst);
		xfer_t x;
		x.reg_select  = rs;
		x.nibble      = nib;
		x.wait_before = wb;
		x.wait_after  = wa;
		x.last        = lst;
		return x;
	endfunction

	// a byte is the high nibble then the low nibble; only the low one carries the gap
	function automatic void push_byte(input logic rs, input logic [7:0] b,
			input logic [15:0] gap, input logic lst);
		xfer_expect_q.push_back(mk_xfer(rs, b[7:4], 16'd0, 16'd0, 1'b0));
		xfer_expect_q.push_back(mk_xfer(rs, b[3:0], 16'd0, gap, lst));
	endfunction

	function automatic void plan_request(input req_t r);
		logic [16:0] clr_sum;
		logic [15:0] clr_wait;
		logic [7:0]  ddram_addr;
		clr_sum  = {1'b0, byte_gap_q} + {1'b0, clear_extra_q};
		clr_wait = clr_sum[16] ? 16'hFFFF : clr_sum[15:0];
		ddram_addr = (r.row ? LCD_LINE1_ADDR : LCD_LINE0_ADDR) + {2'b00, r.col};
		case (r.op)
			OP_CMD: begin
				push_byte(1'b0, r.value, byte_gap_q, 1'b1);
			end
			OP_DATA: begin
				push_byte(1'b1, r.value, byte_gap_q, 1'b1);
			end
			OP_CURSOR: begin
				push_byte(1'b0, ddram_addr, byte_gap_q, 1'b1);
			end
			default: begin
				xfer_expect_q.push_back(mk_xfer(1'b0, WAKE_NIB, powerup_wait_q,
					WAKE_WAIT_1ST, 1'b0));
				xfer_expect_q.push_back(mk_xfer(1'b0, WAKE_NIB, 16'd0, WAKE_WAIT_2ND, 1'b0));
				xfer_expect_q.push_back(mk_xfer(1'b0, WAKE_NIB, 16'd0, 16'd0, 1'b0));
				xfer_expect_q.push_back(mk_xfer(1'b0, FOURBIT_NIB, 16'd0, 16'd0, 1'b0));
				push_byte(1'b0, LCD_FUNC_SET, byte_gap_q, 1'b0);
				push_byte(1'b0, LCD_DISP_ON, byte_gap_q, 1'b0);
				push_byte(1'b0, LCD_ENTRY_MODE, byte_gap_q, 1'b0);
				push_byte(1'b0, LCD_CLEAR_DISP, clr_wait, 1'b1);
			end
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				plan_request(req_in);
			if (!start || !busy) begin
				if (req_pending_q.size() == 0) begin
					start <= 1'b0;
				end else if (req_pending_q[0].gap != 0) begin
					req_pending_q[0].gap = req_pending_q[0].gap - 1;
					start <= 1'b0;
				end else begin
					req_head = req_pending_q.pop_front();
					req_in <= req_head.r;
					start  <= 1'b1;
				end
			end
		end
	end

	// transfer monitor and stall watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if (strobe) begin
				if (xfer_expect_q.size() == 0) begin
					$error("unexpected transfer: rs %0d nibble %0h", result.reg_select,
						result.nibble);
					err_cnt++;
				end else begin
					xfer_want = xfer_expect_q.pop_front();
					if (result.reg_select !== xfer_want.reg_select) begin
						$error("reg_select: expected %0d got %0d", xfer_want.reg_select,
							result.reg_select);
						err_cnt++;
					end
					if (result.nibble !== xfer_want.nibble) begin
						$error("nibble: expected %0h got %0h", xfer_want.nibble, result.nibble);
						err_cnt++;
					end
					if (result.wait_before !== xfer_want.wait_before) begin
						$error("wait_before: expected %0d got %0d", xfer_want.wait_before,
							result.wait_before);
						err_cnt++;
					end
					if (result.wait_after !== xfer_want.wait_after) begin
						$error("wait_after: expected %0d got %0d", xfer_want.wait_after,
							result.wait_after);
						err_cnt++;
					end
					if (result.last !== xfer_want.last) begin
						$error("last: expected %0d got %0d", xfer_want.last, result.last);
						err_cnt++;
					end
				end
			end
			if ((start && !busy) || strobe || (psel && penable))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// APB write, then read back the low 16 bits
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_STROBE_WIDTH: strobe_width_q = v[15:0];
			REG_BYTE_GAP:     byte_gap_q     = v[15:0];
			REG_CLEAR_EXTRA:  clear_extra_q  = v[15:0];
			default:          powerup_wait_q = v[15:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[15:0] !== v[15:0]) begin
			$error("register %0d readback: expected %0h got %0h", idx, v[15:0], prdata[15:0]);
			err_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_regs(input logic [31:0] sw, input logic [31:0] gap,
			input logic [31:0] clr, input logic [31:0] pwr);
		reg_write(REG_STROBE_WIDTH, sw);
		reg_write(REG_BYTE_GAP, gap);
		reg_write(REG_CLEAR_EXTRA, clr);
		reg_write(REG_POWERUP_WAIT, pwr);
	endtask

	task automatic add_req(input logic [1:0] op, input logic [7:0] value, input logic row,
			input logic [5:0] col, input int unsigned gap);
		lcd_req_item_t it;
		it.r.op    = op;
		it.r.value = value;
		it.r.row   = row;
		it.r.col   = col;
		it.gap     = gap;
		req_pending_q.push_back(it);
	endtask

	// wait until every request is taken and every transfer seen, then let the pipe settle
	task automatic drain();
		while (req_pending_q.size() != 0 || start || xfer_expect_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int unsigned max_gap);
		int unsigned sel;
		int unsigned gap;
		logic [1:0]  op;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 19);
			op  = (sel < 6) ? OP_CMD : (sel < 12) ? OP_DATA : (sel < 17) ? OP_CURSOR : OP_INIT;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
			add_req(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				6'($urandom_range(0, 63)), gap);
		end
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values, back to back and with gaps
		add_req(OP_CMD, 8'h00, 1'b0, 6'd0, 0);
		add_req(OP_CMD, 8'hFF, 1'b1, 6'd63, 0);
		add_req(OP_DATA, 8'h00, 1'b1, 6'd63, 0);
		add_req(OP_DATA, 8'hFF, 1'b0, 6'd0, 0);
		add_req(OP_DATA, 8'hA5, 1'b0, 6'd21, 0);
		add_req(OP_CMD, 8'h5A, 1'b1, 6'd42, 0);
		add_req(OP_CURSOR, 8'h00, 1'b0, 6'd0, 0);
		add_req(OP_CURSOR, 8'hFF, 1'b0, 6'd63, 0);
		add_req(OP_CURSOR, 8'h00, 1'b1, 6'd0, 0);
		add_req(OP_CURSOR, 8'hFF, 1'b1, 6'd63, 0);
		add_req(OP_INIT, 8'h00, 1'b0, 6'd0, 0);
		add_req(OP_INIT, 8'hFF, 1'b1, 6'd63, 0);
		add_req(OP_DATA, 8'h41, 1'b0, 6'd0, 3);
		add_req(OP_CMD, LCD_CLEAR_DISP, 1'b0, 6'd0, 0);
		add_req(OP_CURSOR, 8'h3C, 1'b1, 6'd15, 1);
		add_req(OP_INIT, 8'h12, 1'b0, 6'd7, 5);
		add_req(OP_DATA, 8'h7E, 1'b1, 6'd1, 0);
		drain();

		// zero strobe width and all waits at minimum
		set_regs(32'd0, 32'd0, 32'd0, 32'd0);
		add_req(OP_INIT, 8'h00, 1'b0, 6'd0, 0);
		run_random(40, 0);

		// everything at maximum; clear wait saturates
		set_regs(32'd65535, 32'd65535, 32'd65535, 32'd65535);
		add_req(OP_INIT, 8'h00, 1'b0, 6'd0, 0);
		run_random(40, 18);

		// upper bits of the write data are dropped; clear wait sums to exactly 0xFFFF
		set_regs(32'hFFFF_0001, 32'h1234_7FFF, 32'hA5A5_8000, 32'hDEAD_ABCD);
		add_req(OP_INIT, 8'h00, 1'b0, 6'd0, 0);
		run_random(40, 18);

		// clear wait one past the top
		reg_write(REG_BYTE_GAP, 32'h0000_8000);
		reg_write(REG_CLEAR_EXTRA, 32'h0000_8000);
		add_req(OP_INIT, 8'h00, 1'b0, 6'd0, 0);
		run_random(40, 4);

		for (int p = 0; p < 3; p++) begin
			set_regs($urandom, $urandom, $urandom, $urandom);
			run_random(40, 18);
		end

		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
